/* rtl/core/fbpa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int ADDR_W     = 32;
  localparam int BS_W       = 16;
  localparam int TB_W       = 6;
  localparam int FREE_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_COUNT = 2'd2;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'd4096;
  localparam logic [BS_W-1:0]   BLK_BYTES_RST = 16'd64;
  localparam logic [TB_W-1:0]   BLK_COUNT_RST = 6'd20;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SPAN,
    S_RANGE,
    S_DIV,
    S_READ,
    S_TEST,
    S_SCAN,
    S_GRANT,
    S_ADDR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic span_load;
    logic div_init;
    logic div_step;
    logic tgt_read;
    logic tgt_clear;
    logic scan_run;
    logic grant_write;
    logic mul_load;
    logic addr_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_release;
    logic in_range;
    logic div_last;
    logic tgt_used;
    logic scan_done;
    logic found;
  } dp_stat_t;

endpackage

/* rtl/core/fbpa_if.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces of the fixed block pool allocator.
interface fbpa_req_if;
  import fbpa_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] release_address;

  modport source(output valid, output command, output release_address, input ready);
  modport sink(input valid, input command, input release_address, output ready);
endinterface

interface fbpa_rsp_if;
  import fbpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] granted_address;
  logic              success;
  logic [FREE_W-1:0] free_count;

  modport source(output valid, output granted_address, output success, output free_count,
                 input ready);
  modport sink(input valid, input granted_address, input success, input free_count,
               output ready);
endinterface

/* rtl/core/fbpa_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the pool allocator: configuration, used-bit memory, scan, divider, result.
module fbpa_datapath #(
  parameter int MAX_BLOCKS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_command,
  input  logic [fbpa_pkg::ADDR_W-1:0]         req_release_address,
  input  fbpa_pkg::dp_cmd_t                   cmd,
  output fbpa_pkg::dp_stat_t                  stat,
  output logic [fbpa_pkg::ADDR_W-1:0]         granted_address,
  output logic                                success,
  output logic [fbpa_pkg::FREE_W-1:0]         free_count
);
  import fbpa_pkg::*;

  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int NW     = (CNT_W > TB_W) ? CNT_W : TB_W;
  localparam int SPAN_W = BS_W + CNT_W;
  localparam int CMP_W  = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
  localparam int REM_W  = BS_W + IDX_W;
  localparam int DC_W   = $clog2(IDX_W + 1);
  localparam int PROD_W = BS_W + IDX_W;

  logic [ADDR_W-1:0] pool_base;
  logic [BS_W-1:0]   blk_bytes;
  logic [TB_W-1:0]   blk_count;

  logic [NW-1:0]     tb_ext;
  logic [CNT_W-1:0]  active_n;

  logic              is_release;
  logic              addr_zero;
  logic [ADDR_W-1:0] offset;
  logic [SPAN_W-1:0] span;

  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  dvs;
  logic [IDX_W-1:0]  quo;
  logic [DC_W-1:0]   div_cnt;
  logic              div_ge;

  logic              used_mem [MAX_BLOCKS];
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_data;

  logic [CNT_W-1:0]  clr_idx;
  logic [CNT_W-1:0]  scan_idx;
  logic              scan_issue;
  logic              scan_vld;
  logic [IDX_W-1:0]  scan_ridx;
  logic [CNT_W-1:0]  free_cnt;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic              cleared;

  logic [ADDR_W-1:0] mul_prod;
  logic [ADDR_W-1:0] grant_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= POOL_BASE_RST;
      blk_bytes <= BLK_BYTES_RST;
      blk_count <= BLK_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE: pool_base <= cfg_data[ADDR_W-1:0];
        CFG_BLK_BYTES: blk_bytes <= cfg_data[BS_W-1:0];
        CFG_BLK_COUNT: blk_count <= cfg_data[TB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tb_ext = NW'(blk_count);
    if (tb_ext > NW'(MAX_BLOCKS)) begin
      active_n = CNT_W'(MAX_BLOCKS);
    end else begin
      active_n = CNT_W'(tb_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_release <= (req_command == CMD_RELEASE);
      addr_zero  <= (req_release_address == '0);
      offset     <= req_release_address - pool_base;
    end
    if (cmd.span_load) begin
      span <= SPAN_W'(blk_bytes) * SPAN_W'(active_n);
    end
  end

  assign div_ge = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= REM_W'(offset);
      dvs     <= REM_W'(blk_bytes) << (IDX_W - 1);
      quo     <= '0;
      div_cnt <= DC_W'(IDX_W);
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem <= rem - dvs;
      end
      quo     <= IDX_W'({quo, div_ge});
      dvs     <= dvs >> 1;
      div_cnt <= div_cnt - DC_W'(1);
    end
  end

  assign scan_issue = cmd.scan_run && (scan_idx < active_n);
  assign rd_en      = cmd.tgt_read || scan_issue;
  assign rd_addr    = cmd.tgt_read ? quo : scan_idx[IDX_W-1:0];

  always_comb begin
    wr_en   = cmd.clr_step || cmd.tgt_clear || cmd.grant_write;
    wr_data = cmd.grant_write;
    if (cmd.clr_step) begin
      wr_addr = clr_idx[IDX_W-1:0];
    end else if (cmd.tgt_clear) begin
      wr_addr = quo;
    end else begin
      wr_addr = found_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= used_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_idx <= '0;
      scan_vld <= 1'b0;
      free_cnt <= '0;
      found    <= 1'b0;
      cleared  <= 1'b0;
    end else begin
      if (cmd.tgt_clear) begin
        cleared <= 1'b1;
      end
      if (cmd.scan_run) begin
        if (scan_issue) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        scan_vld  <= scan_issue;
        scan_ridx <= scan_idx[IDX_W-1:0];
        if (scan_vld && !rd_data) begin
          free_cnt <= free_cnt + CNT_W'(1);
          if (!found) begin
            found     <= 1'b1;
            found_idx <= scan_ridx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_prod <= ADDR_W'(PROD_W'(found_idx) * PROD_W'(blk_bytes));
    end
    if (cmd.addr_load) begin
      grant_addr <= pool_base + mul_prod;
    end
    if (cmd.out_load) begin
      granted_address <= (!is_release && found) ? grant_addr : '0;
      success         <= is_release ? cleared : found;
      free_count      <= FREE_W'((is_release || !found) ? free_cnt : free_cnt - CNT_W'(1));
    end
  end

  always_comb begin
    stat.clear_done = (clr_idx == CNT_W'(MAX_BLOCKS - 1));
    stat.is_release = is_release;
    stat.in_range   = !addr_zero && (blk_bytes != '0) && (CMP_W'(offset) < CMP_W'(span));
    stat.div_last   = (div_cnt == DC_W'(1));
    stat.tgt_used   = rd_data;
    stat.scan_done  = (scan_idx == active_n) && !scan_vld;
    stat.found      = found;
  end

endmodule

/* rtl/core/fbpa_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the pool allocator.
module fbpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  fbpa_pkg::dp_stat_t stat,
  output fbpa_pkg::dp_cmd_t  cmd
);
  import fbpa_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_SPAN;
      end
      S_SPAN: begin
        state_next = stat.is_release ? S_RANGE : S_SCAN;
      end
      S_RANGE: begin
        state_next = stat.in_range ? S_DIV : S_SCAN;
      end
      S_DIV: begin
        if (stat.div_last) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_TEST;
      end
      S_TEST: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = stat.is_release ? S_DONE : S_GRANT;
      end
      S_GRANT: begin
        state_next = S_ADDR;
      end
      S_ADDR: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_SPAN:  cmd.span_load = 1'b1;
      S_RANGE: cmd.div_init  = stat.in_range;
      S_DIV:   cmd.div_step  = 1'b1;
      S_READ:  cmd.tgt_read  = 1'b1;
      S_TEST:  cmd.tgt_clear = stat.tgt_used;
      S_SCAN:  cmd.scan_run  = 1'b1;
      S_GRANT: begin
        cmd.grant_write = stat.found;
        cmd.mul_load    = 1'b1;
      end
      S_ADDR:  cmd.addr_load = 1'b1;
      S_DONE:  cmd.out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/fixed_block_pool_allocator.sv */
`timescale 1ns / 1ps
// Top level of the fixed block pool allocator.
//
// A request on req carries a command (allocate or release) and, for a release, a byte
// address. Each request yields exactly one response on rsp with the granted address, a
// success flag and the number of free blocks once the request is done. Configuration
// (pool base, block size, block count) is written through cfg_we, cfg_index and cfg_data;
// the user must do so only while no request is in progress, which the block does not enforce.
// After reset the used-bit memory is cleared one entry per cycle; req.ready stays low until
// that pass is complete.
// One request is handled at a time. An allocate scans the used-bit memory one entry per
// cycle over the N active blocks, where N is the active block count, counting free blocks;
// the scan ends after its read latency and end detection. If a free block was found, the
// first one has its used bit set and its address computed before the response is loaded.
// A release inside the pool first runs a restoring divider that resolves one index bit per
// cycle, then reads the target used bit and clears it if set before the scan; a release that
// misses the pool goes straight to the scan. req.ready returns in the cycle after the response is loaded.
// The response sits in an output register. A new request is taken while an earlier response
// is still waiting; it finishes when that response has been transferred.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 32
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
  fbpa_req_if.sink                       req,
  fbpa_rsp_if.source                     rsp
);
  import fbpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fbpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .req_command         (req.command),
    .req_release_address (req.release_address),
    .cmd                 (cmd),
    .stat                (stat),
    .granted_address     (rsp.granted_address),
    .success             (rsp.success),
    .free_count          (rsp.free_count)
  );

endmodule

/* rtl/core/fbpa_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions of the pool allocator and the bind that attaches them.
module fbpa_checker #(
  parameter int MAX_BLOCKS = 32
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fbpa_pkg::ADDR_W-1:0] out_granted,
  input logic                        out_success,
  input logic [fbpa_pkg::FREE_W-1:0] out_free
);
  import fbpa_pkg::*;

  logic [1:0] pending;
  logic [1:0] pending_next;

  always_comb begin
    pending_next = pending;
    if (in_valid && in_ready) pending_next = pending_next + 2'd1;
    if (out_valid && out_ready) pending_next = pending_next - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending_next;
    end
  end

  // A response must always belong to a request that was transferred earlier.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> pending != 2'd0)
    else $error("response without an outstanding request");

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("response dropped before transfer");

  // Only a successful allocation reports a nonzero address.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_granted != '0 |-> out_success)
    else $error("nonzero address without success");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(out_free) <= MAX_BLOCKS)
    else $error("free count above pool size");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(
  .MAX_BLOCKS (MAX_BLOCKS)
) u_fbpa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .out_granted (rsp.granted_address),
  .out_success (rsp.success),
  .out_free    (rsp.free_count)
);
